### hdl/msgd_pkg.sv
// ---------------------------------------------------------------------------
// msgd_pkg
// shared constants and types of the momentum sgd update block
// ---------------------------------------------------------------------------
package msgd_pkg;

  localparam int FpW     = 32;
  localparam int CfgIdxW = 2;
  localparam int FmaLat  = 5;

  localparam logic [FpW-1:0] FpQnan = 32'h7FC0_0000;
  localparam logic [FpW-1:0] FpInf  = 32'h7F80_0000;
  localparam logic [FpW-1:0] FpOne  = 32'h3F80_0000;
  localparam logic [FpW-1:0] FpSign = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LR = 2'd0,
    REG_MC = 2'd1,
    REG_NE = 2'd2,
    REG_WD = 2'd3
  } cfg_reg_e;

endpackage

### hdl/msgd_delay.sv
// ---------------------------------------------------------------------------
// msgd_delay
// enabled shift line that keeps side data aligned with the fma pipeline
// ---------------------------------------------------------------------------
module msgd_delay #(
  parameter int Width = 32,
  parameter int Depth = 5
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

### hdl/msgd_fma.sv
// ---------------------------------------------------------------------------
// msgd_fma
// five stage single precision fused multiply-add, round to nearest even
// ---------------------------------------------------------------------------
module msgd_fma (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [msgd_pkg::FpW-1:0] a_i,
  input  logic [msgd_pkg::FpW-1:0] b_i,
  input  logic [msgd_pkg::FpW-1:0] c_i,
  output logic                    valid_o,
  output logic [msgd_pkg::FpW-1:0] res_o
);
  import msgd_pkg::*;

  typedef struct packed {
    logic           spec;
    logic [FpW-1:0] spec_val;
    logic [47:0]    prod;
    logic [9:0]     eab;
    logic [23:0]    mc;
    logic [7:0]     ecp;
    logic           ps;
    logic           sc;
    logic           cz;
  } st1_t;

  typedef struct packed {
    logic               spec;
    logic [FpW-1:0]     spec_val;
    logic [61:0]        x;
    logic [61:0]        y;
    logic [5:0]         d;
    logic signed [10:0] ex;
    logic               sx;
    logic               sy;
  } st2_t;

  typedef struct packed {
    logic               spec;
    logic [FpW-1:0]     spec_val;
    logic [62:0]        s;
    logic signed [10:0] xs;
    logic               sr;
  } st3_t;

  typedef struct packed {
    logic               spec;
    logic [FpW-1:0]     spec_val;
    logic [62:0]        s;
    logic signed [10:0] shift;
    logic [7:0]         tb;
    logic               sr;
  } st4_t;

  function automatic logic [5:0] msb63(input logic [62:0] v);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) k = 6'(i);
    end
    return k;
  endfunction

  logic [4:0] v_q;
  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  st4_t s4_d, s4_q;
  logic [FpW-1:0] res_d, res_q;

  // stage 1: unpack, special operands, mantissa product
  always_comb begin
    logic [7:0]  ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic        az, bz, cz, nan, ps, sc;
    logic [23:0] ma, mb;
    logic [8:0]  eap, ebp;
    ea = a_i[30:23]; fa = a_i[22:0];
    eb = b_i[30:23]; fb = b_i[22:0];
    ec = c_i[30:23]; fc = c_i[22:0];
    ps = a_i[31] ^ b_i[31];
    sc = c_i[31];
    az = (ea == 8'd0) && (fa == 23'd0);
    bz = (eb == 8'd0) && (fb == 23'd0);
    cz = (ec == 8'd0) && (fc == 23'd0);
    nan = ((ea == 8'hFF) && (fa != 23'd0)) || ((eb == 8'hFF) && (fb != 23'd0)) ||
          ((ec == 8'hFF) && (fc != 23'd0));
    ma = {ea != 8'd0, fa};
    mb = {eb != 8'd0, fb};
    eap = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
    ebp = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
    s1_d.spec     = 1'b1;
    s1_d.spec_val = '0;
    if (nan) begin
      s1_d.spec_val = FpQnan;
    end else if ((ea == 8'hFF) || (eb == 8'hFF)) begin
      if (az || bz) s1_d.spec_val = FpQnan;
      else if ((ec == 8'hFF) && (sc != ps)) s1_d.spec_val = FpQnan;
      else s1_d.spec_val = {ps, FpInf[30:0]};
    end else if (ec == 8'hFF) begin
      s1_d.spec_val = c_i;
    end else if (az || bz) begin
      s1_d.spec_val = cz ? {ps & sc, 31'd0} : c_i;
    end else begin
      s1_d.spec = 1'b0;
    end
    s1_d.prod = 48'(ma) * 48'(mb);
    s1_d.eab  = 10'(eap) + 10'(ebp);
    s1_d.mc   = {ec != 8'd0, fc};
    s1_d.ecp  = (ec == 8'd0) ? 8'd1 : ec;
    s1_d.ps   = ps;
    s1_d.sc   = sc;
    s1_d.cz   = cz;
  end

  // stage 2: normalize both terms, order them by exponent
  always_comb begin
    logic [5:0]         kp, kq;
    logic [61:0]        pn, qn;
    logic signed [10:0] xp, xq, diff;
    kp = msb63(63'(s1_q.prod));
    kq = msb63(63'(s1_q.mc));
    pn = 62'(s1_q.prod) << (6'd61 - kp);
    qn = 62'(s1_q.mc) << (6'd61 - kq);
    xp = $signed(11'(s1_q.eab) + 11'(kp)) - 11'sd361;
    xq = $signed(11'(s1_q.ecp) + 11'(kq)) - 11'sd211;
    s2_d.spec     = s1_q.spec;
    s2_d.spec_val = s1_q.spec_val;
    diff = '0;
    if (s1_q.cz) begin
      s2_d.x = pn; s2_d.ex = xp; s2_d.sx = s1_q.ps;
      s2_d.y = '0; s2_d.sy = s1_q.ps;
    end else if (xp >= xq) begin
      s2_d.x = pn; s2_d.ex = xp; s2_d.sx = s1_q.ps;
      s2_d.y = qn; s2_d.sy = s1_q.sc;
      diff = xp - xq;
    end else begin
      s2_d.x = qn; s2_d.ex = xq; s2_d.sx = s1_q.sc;
      s2_d.y = pn; s2_d.sy = s1_q.ps;
      diff = xq - xp;
    end
    s2_d.d = (diff >= 11'sd63) ? 6'd63 : diff[5:0];
  end

  // stage 3: align smaller term with sticky, add or subtract
  always_comb begin
    logic [63:0] mask;
    logic        sticky;
    logic [61:0] ys;
    mask   = (64'd1 << s2_q.d) - 64'd1;
    sticky = |({2'b00, s2_q.y} & mask);
    ys     = (s2_q.y >> s2_q.d) | 62'(sticky);
    s3_d.spec     = s2_q.spec;
    s3_d.spec_val = s2_q.spec_val;
    s3_d.xs       = s2_q.ex;
    if (s2_q.sx == s2_q.sy) begin
      s3_d.s  = {1'b0, s2_q.x} + {1'b0, ys};
      s3_d.sr = s2_q.sx;
    end else if (s2_q.x >= ys) begin
      s3_d.s  = {1'b0, s2_q.x - ys};
      s3_d.sr = s2_q.sx;
    end else begin
      s3_d.s  = {1'b0, ys - s2_q.x};
      s3_d.sr = s2_q.sy;
    end
  end

  // stage 4: leading one, result exponent, overflow and zero
  always_comb begin
    logic [5:0]         k;
    logic signed [10:0] e, tgt;
    k   = msb63(s3_q.s);
    e   = s3_q.xs + $signed(11'(k));
    tgt = e - 11'sd23;
    if (tgt < -11'sd149) tgt = -11'sd149;
    s4_d.s     = s3_q.s;
    s4_d.sr    = s3_q.sr;
    s4_d.shift = tgt - s3_q.xs;
    s4_d.tb    = 8'(tgt + 11'sd149);
    s4_d.spec     = s3_q.spec;
    s4_d.spec_val = s3_q.spec_val;
    if (!s3_q.spec) begin
      if (s3_q.s == 63'd0) begin
        s4_d.spec     = 1'b1;
        s4_d.spec_val = '0;
      end else if (e >= 11'sd128) begin
        s4_d.spec     = 1'b1;
        s4_d.spec_val = {s3_q.sr, FpInf[30:0]};
      end
    end
  end

  // stage 5: shift into place, round, pack
  always_comb begin
    logic [125:0] ext;
    logic [62:0]  mr;
    logic [24:0]  mant;
    logic [32:0]  bits;
    logic [4:0]   nsh;
    nsh  = 5'(-s4_q.shift);
    ext  = {s4_q.s, 63'd0} >> s4_q.shift[5:0];
    mr   = ext[125:63];
    mant = '0;
    if (s4_q.shift <= 11'sd0) begin
      mant = 25'(s4_q.s[23:0]) << nsh;
    end else if (s4_q.shift <= 11'sd63) begin
      mant = 25'(mr) + 25'(ext[62] && ((|ext[61:0]) || mr[0]));
    end
    bits = (33'(s4_q.tb) << 23) + 33'(mant);
    if (s4_q.spec) begin
      res_d = s4_q.spec_val;
    end else if (bits >= 33'(FpInf)) begin
      res_d = {s4_q.sr, FpInf[30:0]};
    end else begin
      res_d = {s4_q.sr, bits[30:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      res_q <= res_d;
    end
  end

  assign valid_o = v_q[4];
  assign res_o   = res_q;

endmodule

### hdl/momentum_sgd_weight_decay_update.sv
// ---------------------------------------------------------------------------
// momentum_sgd_weight_decay_update
// fp32 momentum sgd step with weight decay, plain or nesterov
// ---------------------------------------------------------------------------
// items enter on in_valid_i / in_stall_o carrying gradient, momentum,
// weight and an end-of-vector flag; results leave on out_valid_o /
// out_stall_i with update, new momentum, new weight and the flag.
// the datapath is six fused multiply-add units, the first two side by
// side, so five in series, each five register stages deep. one item
// is taken every cycle while in_stall_o is low; items are independent.
// the whole pipeline advances together: while a result sits on the
// output and out_stall_i is high, everything holds and in_stall_o is
// raised; nothing is dropped or duplicated. configuration registers
// are written through cfg_we_i / cfg_idx_i / cfg_wdata_i only while no
// item is in flight; the user must see to it, the block does not
// enforce it. reset zeroes the valid bits and all config registers.
// ---------------------------------------------------------------------------
module momentum_sgd_weight_decay_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [msgd_pkg::FpW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [msgd_pkg::FpW-1:0]      gradient_i,
  input  logic [msgd_pkg::FpW-1:0]      momentum_in_i,
  input  logic [msgd_pkg::FpW-1:0]      weight_in_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [msgd_pkg::FpW-1:0]      update_out_o,
  output logic [msgd_pkg::FpW-1:0]      momentum_out_o,
  output logic [msgd_pkg::FpW-1:0]      weight_out_o,
  output logic                          is_last_out_o
);
  import msgd_pkg::*;

  logic [FpW-1:0] lr_q, mc_q, wd_q;
  logic           ne_q;
  logic           adv, in_go;
  logic           dg_v, mm_v, nm_v, t_v, ud_v, w_v;
  logic [FpW-1:0] dg, mm, nm, t, ud, mm_d, nm_d2, nm_d3, w_d, upd, w_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= '0;
      mc_q <= '0;
      ne_q <= 1'b0;
      wd_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LR: lr_q <= cfg_wdata_i;
        REG_MC: mc_q <= cfg_wdata_i;
        REG_NE: ne_q <= cfg_wdata_i[0];
        REG_WD: wd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_o && out_stall_i;
  assign adv        = !in_stall_o;
  assign in_go      = in_valid_i && adv;

  msgd_fma u_dg (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_go),
    .a_i(wd_q), .b_i(weight_in_i), .c_i(gradient_i), .valid_o(dg_v), .res_o(dg)
  );

  msgd_fma u_mm (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_go),
    .a_i(mc_q), .b_i(momentum_in_i), .c_i(FpSign), .valid_o(mm_v), .res_o(mm)
  );

  msgd_fma u_nm (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dg_v && mm_v),
    .a_i(lr_q), .b_i(dg), .c_i(mm), .valid_o(nm_v), .res_o(nm)
  );

  msgd_fma u_ne (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(nm_v),
    .a_i(nm), .b_i(mc_q), .c_i(nm), .valid_o(t_v), .res_o(t)
  );

  msgd_delay #(.Width(FpW), .Depth(2*FmaLat)) u_mm_dly (
    .clk_i, .en_i(adv), .d_i(mm), .q_o(mm_d)
  );

  msgd_fma u_ud (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(t_v),
    .a_i(t), .b_i(FpOne), .c_i(mm_d ^ FpSign), .valid_o(ud_v), .res_o(ud)
  );

  msgd_delay #(.Width(FpW), .Depth(2*FmaLat)) u_nm_dly2 (
    .clk_i, .en_i(adv), .d_i(nm), .q_o(nm_d2)
  );

  msgd_delay #(.Width(FpW), .Depth(FmaLat)) u_nm_dly3 (
    .clk_i, .en_i(adv), .d_i(nm_d2), .q_o(nm_d3)
  );

  msgd_delay #(.Width(FpW), .Depth(4*FmaLat)) u_w_dly (
    .clk_i, .en_i(adv), .d_i(weight_in_i), .q_o(w_d)
  );

  msgd_delay #(.Width(1), .Depth(5*FmaLat)) u_last_dly (
    .clk_i, .en_i(adv), .d_i(is_last_i), .q_o(is_last_out_o)
  );

  assign upd = ne_q ? ud : nm_d2;

  msgd_fma u_wt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(ud_v),
    .a_i(w_d), .b_i(FpOne), .c_i(upd ^ FpSign), .valid_o(w_v), .res_o(w_new)
  );

  msgd_delay #(.Width(FpW), .Depth(FmaLat)) u_upd_dly (
    .clk_i, .en_i(adv), .d_i(upd), .q_o(update_out_o)
  );

  assign out_valid_o    = w_v;
  assign weight_out_o   = w_new;
  assign momentum_out_o = nm_d3;

endmodule
